FILE: rtl/dhkt_pkg.sv
// Package for the double-hash key table.
// Holds the sequencer state type, status and operation codes and hash constants.
// No dependencies.
package dhkt_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_H2_RECIP,
        ST_H2_SUB,
        ST_DIV_H1,
        ST_DIV_STEP,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STAT_STORED    = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_FOUND     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [31:0] HASH_MULT = 32'd31;
    localparam logic [11:0] HASH2_MOD = 12'd3500;
    localparam int          HASH2_ROT = 5;

    // 2^16, 2^32 and 2^48 modulo 3500, for folding the 64-bit second hash
    localparam logic [11:0] H2_FOLD16 = 12'd2536;
    localparam logic [11:0] H2_FOLD32 = 12'd1796;
    localparam logic [11:0] H2_FOLD48 = 12'd1156;
    // ceil(2^42 / 3500), exact quotient for any folded value below 2^30
    localparam logic [31:0] H2_RECIP    = 32'd1256584718;
    localparam int          H2_RECIP_SH = 42;

    localparam int CFG_W  = 13;
    localparam int SLOT_W = 12;

endpackage

FILE: rtl/double_hash_key_table.sv
// Double-hash key table: open addressing over one slot RAM, shared bit-serial divider.
// Depends on dhkt_pkg and dhkt_ram.
// After reset a clearing pass empties the RAM; no request is taken then.
// Per request: accept, hash over the key characters, h2 (reciprocal mult, subtract), divider
// for h1 then for the step, a RAM read and check per probe, then the hand-over.
// One request at a time; a result held by m_tready stalls the hand-over and the input.
module double_hash_key_table #(
    parameter int TABLE_DEPTH = 4096,
    parameter int KEY_CHARS   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,   // table_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,       // key[63:0], record[95:64]
    input  logic        s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // found_record[31:0], slot[43:32], zero pad
    output logic [1:0]  m_tuser        // status
);
    import dhkt_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int N_W    = $clog2(TABLE_DEPTH + 1);
    localparam int DV_W   = (N_W > 12) ? N_W : 12;
    localparam int RAM_W  = 97;
    localparam int CHR_W  = 4;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]  tsize_reg, tsize_next;
    logic              op_reg, op_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       shk_reg, shk_next;
    logic [31:0]       rec_reg, rec_next;
    logic [CHR_W-1:0]  chr_reg, chr_next;
    logic [31:0]       h_reg, h_next;
    logic [63:0]       s_reg, s_next;
    logic [11:0]       h2_reg, h2_next;
    logic [29:0]       fold_reg, fold_next;
    logic [17:0]       q_reg, q_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [N_W-1:0]    pcnt_reg, pcnt_next;
    logic [63:0]       dvd_reg, dvd_next;
    logic [DV_W-1:0]   rem_reg, rem_next;
    logic [DV_W-1:0]   dsr_reg, dsr_next;
    logic [6:0]        dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [31:0]       rrec_reg, rrec_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic              mval_reg, mval_next;
    logic [1:0]        mstat_reg, mstat_next;
    logic [31:0]       mrec_reg, mrec_next;
    logic [SLOT_W-1:0] mslot_reg, mslot_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;

    logic [DV_W:0]     trial;
    logic [DV_W-1:0]   rem_new;
    logic              div_last;
    logic [63:0]       norm_key;
    logic              alive;
    logic [7:0]        chr;
    logic [31:0]       ts32, habs, t32, slot32;
    logic [N_W-1:0]    n_in;
    logic [29:0]       h2_fold;
    logic [61:0]       h2_prod;
    logic [29:0]       h2_diff;

    dhkt_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            tsize_reg <= CFG_W'(4096);
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            tsize_reg <= tsize_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        shk_reg   <= shk_next;
        rec_reg   <= rec_next;
        chr_reg   <= chr_next;
        h_reg     <= h_next;
        s_reg     <= s_next;
        h2_reg    <= h2_next;
        fold_reg  <= fold_next;
        q_reg     <= q_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        pcnt_reg  <= pcnt_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        dcnt_reg  <= dcnt_next;
        rstat_reg <= rstat_next;
        rrec_reg  <= rrec_next;
        rslot_reg <= rslot_next;
        mstat_reg <= mstat_next;
        mrec_reg  <= mrec_next;
        mslot_reg <= mslot_next;
    end

    // key cut at first zero byte or KEY_CHARS characters
    always_comb begin
        alive    = 1'b1;
        norm_key = '0;
        for (int k = 0; k < 8; k++) begin
            if (s_tdata[63-8*k -: 8] == 8'd0 || k >= KEY_CHARS) begin
                alive = 1'b0;
            end
            if (alive) begin
                norm_key[63-8*k -: 8] = s_tdata[63-8*k -: 8];
            end
        end
    end

    always_comb begin
        ts32 = {19'd0, tsize_reg};
        if (ts32 == 32'd0) begin
            n_in = N_W'(1);
        end else if (ts32 > 32'(TABLE_DEPTH)) begin
            n_in = N_W'(TABLE_DEPTH);
        end else begin
            n_in = ts32[N_W-1:0];
        end
    end

    // second hash modulo 3500: fold to 30 bits, reciprocal quotient, subtract
    always_comb begin
        h2_fold = {14'd0, s_reg[15:0]}
                + {14'd0, s_reg[31:16]} * {18'd0, H2_FOLD16}
                + {14'd0, s_reg[47:32]} * {18'd0, H2_FOLD32}
                + {14'd0, s_reg[63:48]} * {18'd0, H2_FOLD48};
        h2_prod = {32'd0, fold_reg} * {30'd0, H2_RECIP};
        h2_diff = fold_reg - {12'd0, q_reg} * {18'd0, HASH2_MOD};
    end

    // shared restoring divider step
    always_comb begin
        trial    = {rem_reg, dvd_reg[63]};
        rem_new  = (trial >= {1'b0, dsr_reg}) ? DV_W'(trial - {1'b0, dsr_reg})
                                              : trial[DV_W-1:0];
        div_last = (dcnt_reg == 7'd63);
    end

    always_comb begin
        state_next = state_reg;
        tsize_next = cfg_wr_en ? cfg_wr_data : tsize_reg;
        clr_next   = clr_reg;
        mval_next  = mval_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        shk_next   = shk_reg;
        rec_next   = rec_reg;
        chr_next   = chr_reg;
        h_next     = h_reg;
        s_next     = s_reg;
        h2_next    = h2_reg;
        fold_next  = fold_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        pcnt_next  = pcnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        dcnt_next  = dcnt_reg;
        rstat_next = rstat_reg;
        rrec_next  = rrec_reg;
        rslot_next = rslot_reg;
        mstat_next = mstat_reg;
        mrec_next  = mrec_reg;
        mslot_next = mslot_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = {1'b1, key_reg, rec_reg};
        s_tready   = 1'b0;
        chr        = shk_reg[63:56];
        habs       = h_reg[31] ? (32'd0 - h_reg) : h_reg;
        t32        = '0;
        slot32     = 32'(idx_reg);

        if (m_tvalid && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = norm_key;
                    shk_next   = norm_key;
                    rec_next   = s_tdata[95:64];
                    n_next     = n_in;
                    chr_next   = '0;
                    h_next     = '0;
                    s_next     = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (chr == 8'd0 || chr_reg == CHR_W'(KEY_CHARS)) begin
                    fold_next  = h2_fold;
                    state_next = ST_H2_RECIP;
                end else begin
                    h_next   = h_reg * HASH_MULT + {24'd0, chr};
                    s_next   = {s_reg[63-HASH2_ROT:0], s_reg[63:64-HASH2_ROT]}
                               + {56'd0, chr};
                    shk_next = {shk_reg[55:0], 8'd0};
                    chr_next = chr_reg + 1'b1;
                end
            end
            ST_H2_RECIP: begin
                q_next     = h2_prod[H2_RECIP_SH+17:H2_RECIP_SH];
                state_next = ST_H2_SUB;
            end
            ST_H2_SUB: begin
                h2_next    = h2_diff[11:0];
                rem_next   = '0;
                dsr_next   = DV_W'(n_reg);
                dvd_next   = {habs, 32'd0};
                dcnt_next  = 7'd32;
                state_next = ST_DIV_H1;
            end
            ST_DIV_H1, ST_DIV_STEP: begin
                dvd_next  = {dvd_reg[62:0], 1'b0};
                rem_next  = rem_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (div_last) begin
                    rem_next  = '0;
                    dsr_next  = DV_W'(n_reg);
                    case (state_reg)
                        ST_DIV_H1: begin
                            t32 = 32'(rem_new);
                            if (h_reg[31] && t32 != 32'd0) begin
                                t32 = 32'(n_reg) - t32;
                            end
                            idx_next   = t32[IDX_W-1:0];
                            dvd_next   = {h2_reg, 52'd0};
                            dcnt_next  = 7'd52;
                            state_next = ST_DIV_STEP;
                        end
                        default: begin
                            step_next  = rem_new[IDX_W-1:0];
                            pcnt_next  = '0;
                            state_next = ST_PROBE_RD;
                        end
                    endcase
                end
            end
            ST_PROBE_RD: begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
                rrec_next  = '0;
                rslot_next = '0;
                if (!ram_rdata[RAM_W-1]) begin
                    if (op_reg == OP_STORE) begin
                        ram_we     = 1'b1;
                        rstat_next = STAT_STORED;
                        rslot_next = slot32[SLOT_W-1:0];
                    end else begin
                        rstat_next = STAT_NOT_FOUND;
                    end
                    state_next = ST_DONE;
                end else if (op_reg == OP_FETCH && ram_rdata[95:32] == key_reg) begin
                    rstat_next = STAT_FOUND;
                    rrec_next  = ram_rdata[31:0];
                    rslot_next = slot32[SLOT_W-1:0];
                    state_next = ST_DONE;
                end else if (pcnt_reg + 1'b1 == n_reg) begin
                    rstat_next = (op_reg == OP_STORE) ? STAT_FULL : STAT_NOT_FOUND;
                    state_next = ST_DONE;
                end else begin
                    pcnt_next = pcnt_reg + 1'b1;
                    t32 = 32'(idx_reg) + 32'(step_reg);
                    if (t32 >= 32'(n_reg)) begin
                        t32 = t32 - 32'(n_reg);
                    end
                    idx_next   = t32[IDX_W-1:0];
                    state_next = ST_PROBE_RD;
                end
            end
            ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mstat_next = rstat_reg;
                    mrec_next  = rrec_reg;
                    mslot_next = rslot_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mval_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = {4'd0, mslot_reg, mrec_reg};

endmodule

FILE: rtl/dhkt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dhkt_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
